@@ rtl/cdid_pkg.sv @@
// ----------------------------------------------------------------------------
// cdid_pkg: shared types, constants and helpers for the disc id core
// Holds field widths, the constant reciprocals used for the divisions by 75
// and 100, the small decimal digit-sum helper and the stage structures.
// ----------------------------------------------------------------------------
package cdid_pkg;

   localparam int unsigned SECTOR_W = 20;   // track start / end sector
   localparam int unsigned LEAD_W   = 21;   // end sector + 1
   localparam int unsigned SECS_W   = 14;   // seconds of a sector address
   localparam int unsigned DIGIT_W  = 6;    // digit sum of one seconds value
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned DTOT_W   = 16;
   localparam int unsigned ID_W     = 32;
   localparam int unsigned PLAY_W   = 24;

   localparam logic [COUNT_W-1:0] MAX_TRACKS = 8'd99;

   // Lead-in offset that turns an absolute frame address into seconds.
   localparam logic [LEAD_W-1:0] SECTOR_BIAS = 21'd150;

   // x / 75 == (x * RECIP75) >> RECIP75_SHIFT for every x below 2^21.
   localparam int unsigned RECIP75_SHIFT = 26;
   localparam logic [19:0] RECIP75 = 20'((64'd1 << RECIP75_SHIFT) / 75 + 1);

   // x / 100 == (x * RECIP100) >> RECIP100_SHIFT for every x below 2^14.
   localparam int unsigned RECIP100_SHIFT = 19;
   localparam logic [12:0] RECIP100 = 13'd5243;

   // Track after the seconds conversion and digit sum.
   typedef struct packed {
      logic [SECTOR_W-1:0] start;
      logic [SECS_W-1:0]   secs;
      logic [DIGIT_W-1:0]  digits;
      logic [LEAD_W-1:0]   leadout;
      logic [SECS_W-1:0]   lead_secs;
      logic                last;
   } trk_type;

   // Totals of a finished table of contents, ready for packing.
   typedef struct packed {
      logic [ID_W-1:0]    offset;
      logic [ID_W-1:0]    weighted;
      logic [DTOT_W-1:0]  digit_total;
      logic [COUNT_W-1:0] count;
      logic [SECS_W-1:0]  first_secs;
      logic [LEAD_W-1:0]  leadout;
      logic [SECS_W-1:0]  lead_secs;
   } fin_type;

   // Seconds of a sector address: (sector + 150) / 75.
   function automatic logic [SECS_W-1:0] sector_secs(input logic [LEAD_W-1:0] sector);
      logic [LEAD_W-1:0]    biased;
      logic [LEAD_W+19:0]   prod;
      biased = sector + SECTOR_BIAS;
      prod   = biased * RECIP75;
      return prod[RECIP75_SHIFT +: SECS_W];
   endfunction

   // Decimal digit sum of a value below 200.
   function automatic logic [4:0] digit_sum_small(input logic [7:0] v);
      logic       hundred;
      logic [7:0] rest;
      logic [3:0] tens;
      logic [7:0] ones;
      hundred = (v >= 8'd100);
      rest    = hundred ? v - 8'd100 : v;
      tens    = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (rest >= 8'(10 * i)) begin
            tens = 4'(i);
         end
      end
      ones = rest - 8'(int'(tens) * 10);
      return 5'(hundred) + {1'b0, tens} + ones[4:0];
   endfunction

endpackage

@@ rtl/cd_toc_disc_id_core.sv @@
// ----------------------------------------------------------------------------
// cd_toc_disc_id_core: disc identifiers from a CD table of contents
// The table of contents enters one track per beat on the req_ channel: the
// track's start sector, and on the final track also its end sector with
// req_last_track high. Tracks that are not last produce no result. After a
// last track the core returns one beat on the rsp_ channel carrying the
// offset sum id, the weighted id, the packed id and the track count, then
// starts the next disc from empty totals.
// A track beat is taken every cycle while req_stall is low. The pipeline is five
// registers deep (input, seconds conversion, digit sum, accumulators, result),
// and the last track's beat passes through them in that order to the result.
// Reset clears all totals and empties the pipeline. While a result beat is
// stalled the whole pipeline holds and req_stall is raised; req_stall is low
// whenever the result register is empty or being taken in that cycle.
// ----------------------------------------------------------------------------
module cd_toc_disc_id_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cdid_pkg::SECTOR_W-1:0]   req_start_sector,
   input  logic [cdid_pkg::SECTOR_W-1:0]   req_end_sector,
   input  logic                            req_last_track,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cdid_pkg::ID_W-1:0]       rsp_sum_id,
   output logic [cdid_pkg::ID_W-1:0]       rsp_weighted_id,
   output logic [cdid_pkg::ID_W-1:0]       rsp_packed_id,
   output logic [cdid_pkg::COUNT_W-1:0]    rsp_track_count
);
   import cdid_pkg::*;

   logic    go;
   logic    trk_valid;
   trk_type trk;
   logic    fin_valid;
   fin_type fin;

   // Every stage advances together unless a result beat is held.
   assign go        = !(rsp_valid && rsp_stall);
   assign req_stall = !go;

   cdid_front u_front (
      .clock            (clock),
      .reset            (reset),
      .go               (go),
      .req_valid        (req_valid),
      .req_start_sector (req_start_sector),
      .req_end_sector   (req_end_sector),
      .req_last_track   (req_last_track),
      .trk_valid        (trk_valid),
      .trk              (trk)
   );

   cdid_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .trk_valid (trk_valid),
      .trk       (trk),
      .fin_valid (fin_valid),
      .fin       (fin)
   );

   cdid_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .go              (go),
      .fin_valid       (fin_valid),
      .fin             (fin),
      .rsp_valid       (rsp_valid),
      .rsp_sum_id      (rsp_sum_id),
      .rsp_weighted_id (rsp_weighted_id),
      .rsp_packed_id   (rsp_packed_id),
      .rsp_track_count (rsp_track_count)
   );

endmodule

@@ rtl/cdid_front.sv @@
// ----------------------------------------------------------------------------
// cdid_front: input register, seconds conversion and digit sum
// Three register stages that turn a raw track beat into its seconds value,
// its decimal digit sum and the leadout figures used on the last track.
// ----------------------------------------------------------------------------
module cdid_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            go,
   input  logic                            req_valid,
   input  logic [cdid_pkg::SECTOR_W-1:0]   req_start_sector,
   input  logic [cdid_pkg::SECTOR_W-1:0]   req_end_sector,
   input  logic                            req_last_track,
   output logic                            trk_valid,
   output cdid_pkg::trk_type               trk
);
   import cdid_pkg::*;

   logic                in_valid_ff;
   logic [SECTOR_W-1:0] in_start_ff;
   logic [SECTOR_W-1:0] in_end_ff;
   logic                in_last_ff;

   logic    div_valid_ff;
   trk_type div_ff;
   trk_type div_in;

   logic    dig_valid_ff;
   trk_type dig_ff;
   trk_type dig_in;

   logic [26:0] q_prod;
   logic [7:0]  q_hund;
   logic [7:0]  r_hund;

   always_comb begin
      div_in.start     = in_start_ff;
      div_in.secs      = sector_secs({1'b0, in_start_ff});
      div_in.digits    = '0;
      div_in.leadout   = {1'b0, in_end_ff} + LEAD_W'(1);
      div_in.lead_secs = sector_secs(div_in.leadout);
      div_in.last      = in_last_ff;
   end

   // The seconds value is split into hundreds and a remainder below 100,
   // and each part is summed digit by digit.
   always_comb begin
      q_prod        = div_ff.secs * RECIP100;
      q_hund        = q_prod[RECIP100_SHIFT +: 8];
      r_hund        = 8'(div_ff.secs - SECS_W'(int'(q_hund) * 100));
      dig_in        = div_ff;
      dig_in.digits = DIGIT_W'(digit_sum_small(q_hund)) + DIGIT_W'(digit_sum_small(r_hund));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         div_valid_ff <= 1'b0;
         dig_valid_ff <= 1'b0;
      end else if (go) begin
         in_valid_ff  <= req_valid;
         div_valid_ff <= in_valid_ff;
         dig_valid_ff <= div_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         if (req_valid) begin
            in_start_ff <= req_start_sector;
            in_end_ff   <= req_end_sector;
            in_last_ff  <= req_last_track;
         end
         div_ff <= div_in;
         dig_ff <= dig_in;
      end
   end

   assign trk_valid = dig_valid_ff;
   assign trk       = dig_ff;

endmodule

@@ rtl/cdid_accum.sv @@
// ----------------------------------------------------------------------------
// cdid_accum: per-disc accumulators
// Keeps the offset sum, weighted sum, digit total, track count and first
// track seconds; hands the totals on and clears them on the last track.
// ----------------------------------------------------------------------------
module cdid_accum (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic              trk_valid,
   input  cdid_pkg::trk_type trk,
   output logic              fin_valid,
   output cdid_pkg::fin_type fin
);
   import cdid_pkg::*;

   logic [ID_W-1:0]    offset_sum_ff;
   logic [ID_W-1:0]    weighted_sum_ff;
   logic [DTOT_W-1:0]  digit_total_ff;
   logic [COUNT_W-1:0] track_index_ff;
   logic [SECS_W-1:0]  first_seconds_ff;

   logic               fin_valid_ff;
   fin_type            fin_ff;
   fin_type            fin_in;

   logic [COUNT_W-1:0]          count;
   logic [SECTOR_W-1:0]         weight_op;
   logic [SECTOR_W+COUNT_W-1:0] weight_prod;

   always_comb begin
      count = (track_index_ff < MAX_TRACKS) ? track_index_ff + COUNT_W'(1) : track_index_ff;
      // A track starting at sector zero counts as one in the weighted sum.
      weight_op   = (trk.start != '0) ? trk.start : SECTOR_W'(1);
      weight_prod = weight_op * count;

      fin_in.offset      = offset_sum_ff + ID_W'(trk.start);
      fin_in.weighted    = weighted_sum_ff + ID_W'(weight_prod);
      fin_in.digit_total = digit_total_ff + DTOT_W'(trk.digits);
      fin_in.count       = count;
      fin_in.first_secs  = (track_index_ff == '0) ? trk.secs : first_seconds_ff;
      fin_in.leadout     = trk.leadout;
      fin_in.lead_secs   = trk.lead_secs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_sum_ff    <= '0;
         weighted_sum_ff  <= '0;
         digit_total_ff   <= '0;
         track_index_ff   <= '0;
         first_seconds_ff <= '0;
         fin_valid_ff     <= 1'b0;
      end else if (go) begin
         fin_valid_ff <= trk_valid && trk.last;
         if (trk_valid) begin
            if (trk.last) begin
               offset_sum_ff    <= '0;
               weighted_sum_ff  <= '0;
               digit_total_ff   <= '0;
               track_index_ff   <= '0;
               first_seconds_ff <= '0;
            end else begin
               offset_sum_ff    <= fin_in.offset;
               weighted_sum_ff  <= fin_in.weighted;
               digit_total_ff   <= fin_in.digit_total;
               track_index_ff   <= fin_in.count;
               first_seconds_ff <= fin_in.first_secs;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && trk_valid && trk.last) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin       = fin_ff;

endmodule

@@ rtl/cdid_emit.sv @@
// ----------------------------------------------------------------------------
// cdid_emit: leadout fold-in and result register
// Adds the leadout to the sum and leadout*(count+1) to the weighted sum, packs
// the digit, seconds and count id and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module cdid_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic                           fin_valid,
   input  cdid_pkg::fin_type              fin,
   output logic                           rsp_valid,
   output logic [cdid_pkg::ID_W-1:0]      rsp_sum_id,
   output logic [cdid_pkg::ID_W-1:0]      rsp_weighted_id,
   output logic [cdid_pkg::ID_W-1:0]      rsp_packed_id,
   output logic [cdid_pkg::COUNT_W-1:0]   rsp_track_count
);
   import cdid_pkg::*;

   logic                rsp_valid_ff;
   logic [ID_W-1:0]     sum_id_ff;
   logic [ID_W-1:0]     weighted_id_ff;
   logic [ID_W-1:0]     packed_id_ff;
   logic [COUNT_W-1:0]  track_count_ff;

   logic [ID_W-1:0]        sum_id_in;
   logic [ID_W-1:0]        weighted_id_in;
   logic [ID_W-1:0]        packed_id_in;
   logic [COUNT_W:0]       lead_weight;
   logic [LEAD_W+COUNT_W:0] lead_prod;
   logic [8:0]             fold;
   logic [7:0]             digit_mod;
   logic [PLAY_W-1:0]      play;

   always_comb begin
      lead_weight    = {1'b0, fin.count} + (COUNT_W+1)'(1);
      lead_prod      = fin.leadout * lead_weight;
      sum_id_in      = fin.offset + ID_W'(fin.leadout);
      weighted_id_in = fin.weighted + ID_W'(lead_prod);

      // Modulo 255: 2^8 is 1 mod 255, so fold the two bytes and correct.
      fold = {1'b0, fin.digit_total[15:8]} + {1'b0, fin.digit_total[7:0]};
      if (fold >= 9'd510) begin
         digit_mod = 8'(fold - 9'd510);
      end else if (fold >= 9'd255) begin
         digit_mod = 8'(fold - 9'd255);
      end else begin
         digit_mod = fold[7:0];
      end

      play = PLAY_W'(fin.lead_secs) - PLAY_W'(fin.first_secs);
      // The upper seconds bits overlap the digit field and are ORed into it.
      packed_id_in = {digit_mod, 24'd0} | {play, 8'd0} | {24'd0, fin.count};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (go && fin_valid) begin
         sum_id_ff      <= sum_id_in;
         weighted_id_ff <= weighted_id_in;
         packed_id_ff   <= packed_id_in;
         track_count_ff <= fin.count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sum_id      = sum_id_ff;
   assign rsp_weighted_id = weighted_id_ff;
   assign rsp_packed_id   = packed_id_ff;
   assign rsp_track_count = track_count_ff;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the disc id core
// Drives tables of contents into the core one track per beat, predicts the
// sum, weighted and packed ids of each finished disc with an independent
// model, and compares every result beat field by field against the oldest
// prediction. Directed discs cover the sector extremes, zero start sectors,
// a leadout ahead of the first track, the ignored end sector and a disc
// long enough to saturate the track count, and random discs run under
// varying idle and stall rates.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned TAIL_CYCLES    = 20;

   typedef struct {
      logic [31:0] sum_id;
      logic [31:0] weighted_id;
      logic [31:0] packed_id;
      logic [7:0]  track_count;
   } disc_ids_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [19:0] req_start_sector = '0;
   logic [19:0] req_end_sector   = '0;
   logic        req_last_track   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_sum_id;
   logic [31:0] rsp_weighted_id;
   logic [31:0] rsp_packed_id;
   logic [7:0]  rsp_track_count;

   // Predictor state for the disc currently being taken in.
   logic [31:0] toc_offset_sum   = '0;
   logic [31:0] toc_weighted_sum = '0;
   logic [15:0] toc_digit_total  = '0;
   logic [7:0]  toc_tracks       = '0;
   logic [13:0] toc_first_secs   = '0;

   disc_ids_type pending_ids[$];
   int unsigned  send_idle_pct    = 0;
   int unsigned  recv_stall_pct   = 0;
   int unsigned  tracks_sent      = 0;
   int unsigned  mismatches       = 0;
   int unsigned  quiet_cycles     = 0;

   cd_toc_disc_id_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_sector (req_start_sector),
      .req_end_sector   (req_end_sector),
      .req_last_track   (req_last_track),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sum_id       (rsp_sum_id),
      .rsp_weighted_id  (rsp_weighted_id),
      .rsp_packed_id    (rsp_packed_id),
      .rsp_track_count  (rsp_track_count)
   );

   always #2 clock = ~clock;

   // Adds one accepted track to the running totals and, on the last track,
   // queues the ids the core must return for the disc.
   function automatic void accumulate_track(input logic [19:0] start,
                                            input logic [19:0] end_sect,
                                            input logic last);
      logic [31:0]  secs;
      logic [31:0]  weight;
      logic [31:0]  rest;
      logic [31:0]  digits;
      logic [31:0]  leadout;
      logic [31:0]  lead_secs;
      logic [31:0]  play;
      disc_ids_type ids;
      secs = (32'(start) + 32'd150) / 32'd75;
      if (toc_tracks == 8'd0) begin
         toc_first_secs = secs[13:0];
      end
      weight = 32'(toc_tracks);
      if (weight < 32'(cdid_pkg::MAX_TRACKS)) begin
         weight = weight + 32'd1;
      end
      toc_tracks = weight[7:0];
      digits = 32'd0;
      rest   = secs;
      while (rest != 32'd0) begin
         digits = digits + rest % 32'd10;
         rest   = rest / 32'd10;
      end
      toc_offset_sum   = toc_offset_sum + 32'(start);
      // A zero start sector still counts with weight one.
      toc_weighted_sum = toc_weighted_sum + ((start != 20'd0) ? 32'(start) : 32'd1) * weight;
      toc_digit_total  = toc_digit_total + digits[15:0];
      if (last) begin
         leadout   = 32'(end_sect) + 32'd1;
         lead_secs = (leadout + 32'd150) / 32'd75;
         // The playing time wraps when the leadout lies ahead of the first
         // track, and its upper bits then merge into the digit field.
         play      = (lead_secs - 32'(toc_first_secs)) & 32'h00FF_FFFF;
         ids.sum_id      = toc_offset_sum + leadout;
         ids.weighted_id = toc_weighted_sum + leadout * (weight + 32'd1);
         ids.packed_id   = ((32'(toc_digit_total) % 32'd255) << 24) | (play << 8)
                           | 32'(weight[7:0]);
         ids.track_count = weight[7:0];
         pending_ids.push_back(ids);
         toc_offset_sum   = '0;
         toc_weighted_sum = '0;
         toc_digit_total  = '0;
         toc_tracks       = '0;
         toc_first_secs   = '0;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t ns: %s is 0x%08h, expected 0x%08h", $time, what, got, want);
      mismatches++;
   endtask

   // Sends one track beat and returns at the edge where it is accepted.
   // The valid is left high so back-to-back beats need no extra step.
   task automatic send_track(input logic [19:0] start, input logic [19:0] end_sect,
                             input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_start_sector <= start;
      req_end_sector   <= end_sect;
      req_last_track   <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      accumulate_track(start, end_sect, last);
      tracks_sent++;
   endtask

   // Holds the sender off until every predicted disc has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_ids.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One disc: either an ascending table with sensible gaps, or noise in
   // every field. End sectors of tracks that are not last are always noise.
   task automatic send_disc(input int unsigned tracks, input bit noisy,
                            input int unsigned max_step);
      int unsigned sector;
      int unsigned end_sect;
      bit          last;
      sector = $urandom_range(300);
      for (int i = 0; i < tracks; i++) begin
         last = (i == tracks - 1);
         if (noisy) begin
            send_track(20'($urandom), 20'($urandom), last);
         end else begin
            end_sect = last ? sector + $urandom_range(max_step) : $urandom;
            send_track(20'(sector), 20'(end_sect), last);
            sector = sector + $urandom_range(max_step, 1);
         end
      end
   endtask

   task automatic test_sector_extremes();
      send_track(20'h00000, 20'h00000, 1'b1);
      send_track(20'hFFFFF, 20'hFFFFF, 1'b1);
      send_track(20'h00000, 20'hFFFFF, 1'b1);
      // Leadout far ahead of the first track: playing time wraps.
      send_track(20'hFFFFF, 20'h00000, 1'b1);
      wait_drain();
   endtask

   task automatic test_zero_start_weight();
      send_track(20'h00000, 20'hFFFFF, 1'b0);
      send_track(20'h00000, 20'h00000, 1'b0);
      send_track(20'h00001, 20'h55555, 1'b0);
      send_track(20'h00000, 20'h00000, 1'b1);
      wait_drain();
   endtask

   task automatic test_ignored_end_sector();
      send_track(20'h00096, 20'hFFFFF, 1'b0);
      send_track(20'h02EE0, 20'h00000, 1'b0);
      send_track(20'h0AAAA, 20'hAAAAA, 1'b0);
      send_track(20'h15555, 20'h2FFFF, 1'b1);
      wait_drain();
   endtask

   task automatic test_typical_disc();
      send_disc(10, 1'b0, 40000);
      wait_drain();
   endtask

   // Runs past the track limit, then checks that the next disc starts clean.
   task automatic test_track_saturation();
      send_disc(104, 1'b0, 9000);
      send_disc(2, 1'b0, 30000);
      wait_drain();
   endtask

   task automatic test_random_discs(input int unsigned tracks,
                                    input int unsigned idle_pct,
                                    input int unsigned stall_pct);
      int unsigned stop_at;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      stop_at        = tracks_sent + tracks;
      while (tracks_sent < stop_at) begin
         send_disc($urandom_range(12, 1), $urandom_range(3) == 0, 60000);
         if ($urandom_range(9) == 0) begin
            wait_drain();
         end
      end
      wait_drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_ids
      disc_ids_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ids.size() == 0) begin
            report_mismatch("unexpected result beat, sum_id", rsp_sum_id, 32'd0);
         end else begin
            want = pending_ids.pop_front();
            if (rsp_sum_id !== want.sum_id)
               report_mismatch("sum_id", rsp_sum_id, want.sum_id);
            if (rsp_weighted_id !== want.weighted_id)
               report_mismatch("weighted_id", rsp_weighted_id, want.weighted_id);
            if (rsp_packed_id !== want.packed_id)
               report_mismatch("packed_id", rsp_packed_id, want.packed_id);
            if (rsp_track_count !== want.track_count)
               report_mismatch("track_count", 32'(rsp_track_count), 32'(want.track_count));
         end
      end
   end

   // Ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sector_extremes();
      test_zero_start_weight();
      test_ignored_end_sector();
      test_typical_disc();
      test_random_discs(110, 18, 67);
      test_random_discs(110, 67, 18);
      test_track_saturation();
      test_random_discs(110, 0, 0);
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/cdid_pkg.sv
rtl/cdid_front.sv
rtl/cdid_accum.sv
rtl/cdid_emit.sv
rtl/cd_toc_disc_id_core.sv
sim/testbench.sv
